### hw/rtl/fbc_pkg.sv
// Package for the frustum box culler: default widths, sizes and item codes.
// No dependencies; every file of the block but fbc_rsp_if refers to it by scoped names.
`default_nettype none

package fbc_pkg;

	parameter int COORD_WIDTH = 32;
	parameter int FRAC_BITS   = 16;

	parameter int MAT_WORDS   = 16;
	parameter int MAT_IDX_W   = 4;
	parameter int NUM_AXES    = 3;
	parameter int NUM_TERMS   = 4;
	parameter int NUM_PLANES  = 6;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_TEST = 1'b1
	} action_t;

endpackage

`default_nettype wire

### hw/rtl/fbc_req_if.sv
// Request channel of the culler: matrix loads and box tests.
// Depends on fbc_pkg for the default coordinate width and index width.
`default_nettype none

interface fbc_req_if #(
	parameter int CW = fbc_pkg::COORD_WIDTH
);
	logic                                valid;
	logic                                ready;
	logic                                action;
	logic [fbc_pkg::MAT_IDX_W-1:0]       matrix_index;
	logic signed [CW-1:0]                matrix_value;
	logic signed [CW-1:0]                corner_a_x;
	logic signed [CW-1:0]                corner_a_y;
	logic signed [CW-1:0]                corner_a_z;
	logic signed [CW-1:0]                corner_b_x;
	logic signed [CW-1:0]                corner_b_y;
	logic signed [CW-1:0]                corner_b_z;

	modport source (
		output valid, action, matrix_index, matrix_value,
		output corner_a_x, corner_a_y, corner_a_z,
		output corner_b_x, corner_b_y, corner_b_z,
		input  ready
	);

	modport sink (
		input  valid, action, matrix_index, matrix_value,
		input  corner_a_x, corner_a_y, corner_a_z,
		input  corner_b_x, corner_b_y, corner_b_z,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/fbc_rsp_if.sv
// Response channel of the culler: one visibility flag per box test.
// No dependencies.
`default_nettype none

interface fbc_rsp_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

### hw/rtl/frustum_box_cull.sv
// Top level of the frustum box culler: matrix store, input stage and the
// three pipeline modules. Depends on fbc_pkg, fbc_req_if, fbc_rsp_if,
// fbc_setup, fbc_mul and fbc_reduce.
//
//   channel  dir  carries
//   req      in   matrix word load, or two box corners to test
//   rsp      out  visible flag, one per box test, none per load
//
// One item is taken every cycle unless the pipeline stalls. A test's flag
// passes five registers (input, setup, products, half sums, sign test) on its
// way to rsp; the stages are cut around the 33 x 32 bit multiplier stage and
// the wide sums behind it.
// Each stage holds its item under a stall and frees itself as soon as the
// next stage has room, so bubbles close up. A load writes the store at the
// edge it is taken and is seen by every test taken after it.
// Reset clears the matrix store and all valid bits.
`default_nettype none

module frustum_box_cull #(
	parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = fbc_pkg::FRAC_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fbc_req_if.sink    req,
	fbc_rsp_if.source  rsp
);

	logic signed [COORD_WIDTH-1:0] matrix_q [fbc_pkg::MAT_WORDS];

	logic                          v_s1;
	logic signed [COORD_WIDTH-1:0] corner_a_s1 [fbc_pkg::NUM_AXES];
	logic signed [COORD_WIDTH-1:0] corner_b_s1 [fbc_pkg::NUM_AXES];

	logic                          setup_ready;
	logic                          setup_valid;
	logic signed [COORD_WIDTH-1:0] lo [fbc_pkg::NUM_AXES];
	logic signed [COORD_WIDTH-1:0] hi [fbc_pkg::NUM_AXES];
	logic signed [COORD_WIDTH:0]   plane [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_TERMS];

	logic                          mul_ready;
	logic                          mul_valid;
	logic signed [2*COORD_WIDTH:0] prod [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
	logic signed [COORD_WIDTH:0]   dterm [fbc_pkg::NUM_PLANES];

	logic                          red_ready;
	logic                          accept;
	logic                          is_test;

	assign req.ready = !v_s1 || setup_ready;
	assign accept    = req.valid && req.ready;
	assign is_test   = req.action == fbc_pkg::ACT_TEST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fbc_pkg::MAT_WORDS; i++) begin
				matrix_q[i] <= '0;
			end
		end else if (accept && !is_test) begin
			matrix_q[req.matrix_index] <= req.matrix_value;
		end
	end

	// Loads end here; only tests travel down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= accept && is_test;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_test) begin
			corner_a_s1[0] <= req.corner_a_x;
			corner_a_s1[1] <= req.corner_a_y;
			corner_a_s1[2] <= req.corner_a_z;
			corner_b_s1[0] <= req.corner_b_x;
			corner_b_s1[1] <= req.corner_b_y;
			corner_b_s1[2] <= req.corner_b_z;
		end
	end

	fbc_setup #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (setup_ready),
		.corner_a  (corner_a_s1),
		.corner_b  (corner_b_s1),
		.matrix    (matrix_q),
		.out_valid (setup_valid),
		.out_ready (mul_ready),
		.lo        (lo),
		.hi        (hi),
		.plane     (plane)
	);

	fbc_mul #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (setup_valid),
		.in_ready  (mul_ready),
		.lo        (lo),
		.hi        (hi),
		.plane     (plane),
		.out_valid (mul_valid),
		.out_ready (red_ready),
		.prod      (prod),
		.dterm     (dterm)
	);

	fbc_reduce #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_valid),
		.in_ready  (red_ready),
		.prod      (prod),
		.dterm     (dterm),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.visible   (rsp.visible)
	);

endmodule

`default_nettype wire

### hw/rtl/fbc_setup.sv
// Second pipeline stage: orders the box corners per axis and forms the six
// unnormalised planes from matrix column sums and differences. Depends on fbc_pkg.
`default_nettype none

module fbc_setup #(
	parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] corner_a [fbc_pkg::NUM_AXES],
	input  wire logic signed [COORD_WIDTH-1:0] corner_b [fbc_pkg::NUM_AXES],
	input  wire logic signed [COORD_WIDTH-1:0] matrix [fbc_pkg::MAT_WORDS],
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [COORD_WIDTH-1:0]  lo [fbc_pkg::NUM_AXES],
	output logic signed [COORD_WIDTH-1:0]  hi [fbc_pkg::NUM_AXES],
	output logic signed [COORD_WIDTH:0]    plane [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_TERMS]
);

	localparam int NW = COORD_WIDTH + 1;

	logic                          v_s2;
	logic signed [COORD_WIDTH-1:0] lo_s2 [fbc_pkg::NUM_AXES];
	logic signed [COORD_WIDTH-1:0] hi_s2 [fbc_pkg::NUM_AXES];
	logic signed [NW-1:0]          plane_s2 [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_TERMS];
	logic signed [NW-1:0]          plane_c [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_TERMS];
	logic                          a_less [fbc_pkg::NUM_AXES];

	assign in_ready = !v_s2 || out_ready;

	// Planes come in pairs per matrix column: the fourth column plus, then
	// minus, the chosen one. The last term of each plane is its distance.
	for (genvar p = 0; p < fbc_pkg::NUM_PLANES; p++) begin : g_plane
		localparam int R = p / 2;
		for (genvar c = 0; c < fbc_pkg::NUM_TERMS; c++) begin : g_term
			if (p % 2 == 0) begin : g_add
				assign plane_c[p][c] = NW'(matrix[4 * c + 3]) + NW'(matrix[4 * c + R]);
			end else begin : g_sub
				assign plane_c[p][c] = NW'(matrix[4 * c + 3]) - NW'(matrix[4 * c + R]);
			end
		end
	end

	for (genvar k = 0; k < fbc_pkg::NUM_AXES; k++) begin : g_axis
		assign a_less[k] = corner_a[k] < corner_b[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int k = 0; k < fbc_pkg::NUM_AXES; k++) begin
				lo_s2[k] <= a_less[k] ? corner_a[k] : corner_b[k];
				hi_s2[k] <= a_less[k] ? corner_b[k] : corner_a[k];
			end
			plane_s2 <= plane_c;
		end
	end

	assign out_valid = v_s2;
	assign lo        = lo_s2;
	assign hi        = hi_s2;
	assign plane     = plane_s2;

endmodule

`default_nettype wire

### hw/rtl/fbc_mul.sv
// Third pipeline stage: picks the corner furthest along each plane normal and
// forms the eighteen normal-by-coordinate products. Depends on fbc_pkg.
`default_nettype none

module fbc_mul #(
	parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] lo [fbc_pkg::NUM_AXES],
	input  wire logic signed [COORD_WIDTH-1:0] hi [fbc_pkg::NUM_AXES],
	input  wire logic signed [COORD_WIDTH:0]   plane [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_TERMS],
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [2*COORD_WIDTH:0]  prod [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES],
	output logic signed [COORD_WIDTH:0]    dterm [fbc_pkg::NUM_PLANES]
);

	localparam int NW = COORD_WIDTH + 1;
	localparam int PW = 2 * COORD_WIDTH + 1;
	localparam int DI = fbc_pkg::NUM_TERMS - 1;

	logic                          v_s3;
	logic signed [PW-1:0]          prod_s3 [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
	logic signed [NW-1:0]          dterm_s3 [fbc_pkg::NUM_PLANES];
	logic signed [PW-1:0]          prod_c [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
	logic signed [COORD_WIDTH-1:0] pick [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];

	assign in_ready = !v_s3 || out_ready;

	// A non-negative normal component takes the larger coordinate.
	for (genvar p = 0; p < fbc_pkg::NUM_PLANES; p++) begin : g_plane
		for (genvar k = 0; k < fbc_pkg::NUM_AXES; k++) begin : g_axis
			assign pick[p][k]   = plane[p][k][NW-1] ? lo[k] : hi[k];
			assign prod_c[p][k] = PW'(plane[p][k]) * PW'(pick[p][k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_s3 <= prod_c;
			for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
				dterm_s3[p] <= plane[p][DI];
			end
		end
	end

	assign out_valid = v_s3;
	assign prod      = prod_s3;
	assign dterm     = dterm_s3;

endmodule

`default_nettype wire

### hw/rtl/fbc_reduce.sv
// Fourth and fifth stages: adds the products and the scaled distance term of
// each plane in two halves, then tests the six signs. Depends on fbc_pkg.
`default_nettype none

module fbc_reduce #(
	parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = fbc_pkg::FRAC_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [2*COORD_WIDTH:0] prod [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES],
	input  wire logic signed [COORD_WIDTH:0]   dterm [fbc_pkg::NUM_PLANES],
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           visible
);

	// Three products and one distance term, two guard bits above the product.
	localparam int SW = 2 * COORD_WIDTH + 3;

	logic                 v_s4;
	logic signed [SW-1:0] sum_a_s4 [fbc_pkg::NUM_PLANES];
	logic signed [SW-1:0] sum_b_s4 [fbc_pkg::NUM_PLANES];
	logic                 v_s5;
	logic                 visible_s5;
	logic                 s4_ready;
	logic signed [SW-1:0] total [fbc_pkg::NUM_PLANES];
	logic [fbc_pkg::NUM_PLANES-1:0] behind;

	assign s4_ready = !v_s5 || out_ready;
	assign in_ready = !v_s4 || s4_ready;

	for (genvar p = 0; p < fbc_pkg::NUM_PLANES; p++) begin : g_plane
		assign total[p]  = sum_a_s4[p] + sum_b_s4[p];
		assign behind[p] = total[p][SW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s4 <= in_valid;
			end
			if (s4_ready) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
				sum_a_s4[p] <= SW'(prod[p][0]) + SW'(prod[p][1]);
				sum_b_s4[p] <= SW'(prod[p][2]) + (SW'(dterm[p]) <<< FRAC_BITS);
			end
		end
		if (s4_ready && v_s4) begin
			visible_s5 <= ~|behind;
		end
	end

	assign out_valid = v_s5;
	assign visible   = visible_s5;

endmodule

`default_nettype wire
